// ===== rtl/core/swr_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// swr_pkg: shared types and constants for the sliding window receiver
// Holds the receiver state record, the item and result records, reset
// values and the stream payload widths.
// ---------------------------------------------------------------------------
package swr_pkg;

  // Largest window the block supports
  localparam int WINDOW_MAX_DEF = 128;

  // Field widths
  localparam int NUM_W   = 8;
  localparam int CNT_W   = 8;
  localparam int LIO_W   = NUM_W + 1;

  // Reset values
  localparam logic [NUM_W-1:0] WINDOW_SIZE_RESET = 8'd4;
  localparam logic [CNT_W-1:0] COUNT_MAX         = 8'hFF;
  localparam logic [LIO_W-1:0] LIO_NONE          = 9'h1FF;

  // Stream payload widths
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_FIELD_W = 42;
  localparam int OUT_TDATA_W = 48;

  // Receiver state
  typedef struct packed {
    logic [CNT_W-1:0] buffered_count;
    logic [NUM_W-1:0] expected_start;
    logic [LIO_W-1:0] last_in_order;   // two's complement, -1 = nothing yet
    logic             ack_enable;
    logic             flush_pending;
  } state_t;

  // One received packet header
  typedef struct packed {
    logic [NUM_W-1:0] packet_number;
    logic             short_payload;
  } item_t;

  // One result
  typedef struct packed {
    logic [CNT_W-1:0] commit_count;
    logic [CNT_W-1:0] discard_count;
    logic             accepted;
    logic [CNT_W-1:0] slot;
    logic             ack_valid;
    logic [NUM_W-1:0] ack_number;
    logic             finished;
    logic [CNT_W-1:0] final_count;
  } result_t;

  // State after reset and after completion
  localparam state_t STATE_RESET = '{
    buffered_count: '0,
    expected_start: '0,
    last_in_order:  LIO_NONE,
    ack_enable:     1'b1,
    flush_pending:  1'b0
  };

endpackage

// ===== rtl/core/swr_in_reg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// swr_in_reg: input register stage
// Captures one packet header per transaction and holds it until the
// processing stage takes it; ready stays high while the stage drains.
// ---------------------------------------------------------------------------
module swr_in_reg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [swr_pkg::IN_TDATA_W-1:0]    in_tdata,   // [7:0] packet_number
  input  logic                              in_tlast,   // short_payload
  input  logic                              take,
  output logic                              item_valid,
  output swr_pkg::item_t                    item
);

  logic           valid_r, valid_nxt;
  swr_pkg::item_t item_r;

  assign in_tready = !valid_r || take;

  // Valid flag
  always_comb begin
    valid_nxt = valid_r;
    if (in_tvalid && in_tready) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.packet_number <= in_tdata[swr_pkg::NUM_W-1:0];
      item_r.short_payload <= in_tlast;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// ===== rtl/core/swr_step.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// swr_step: per-packet decision logic
// From the current state and one header, works out flush, in-order check,
// slot assignment, window-end ack and completion, plus the next state.
// ---------------------------------------------------------------------------
module swr_step #(
  parameter int WINDOW_MAX = swr_pkg::WINDOW_MAX_DEF
) (
  input  logic [swr_pkg::NUM_W-1:0] window_size,
  input  swr_pkg::state_t           cur,
  input  swr_pkg::item_t            item,
  output swr_pkg::state_t           nxt,
  output swr_pkg::result_t          res
);

  localparam logic [swr_pkg::NUM_W-1:0] WIN_MAX = swr_pkg::NUM_W'(WINDOW_MAX);

  logic [swr_pkg::NUM_W-1:0] win;
  logic [swr_pkg::LIO_W-1:0] win_m1;
  logic [swr_pkg::LIO_W-1:0] win2_m1;

  // Clamp window into 1 .. WINDOW_MAX
  always_comb begin
    if (window_size == '0) begin
      win = swr_pkg::NUM_W'(1);
    end else if (window_size > WIN_MAX) begin
      win = WIN_MAX;
    end else begin
      win = window_size;
    end
  end

  assign win_m1  = {1'b0, win} - swr_pkg::LIO_W'(1);
  assign win2_m1 = {win, 1'b0} - swr_pkg::LIO_W'(1);

  always_comb begin
    logic [swr_pkg::CNT_W-1:0] bc;
    logic [swr_pkg::NUM_W-1:0] es;
    logic [swr_pkg::LIO_W-1:0] lio;
    logic [swr_pkg::LIO_W-1:0] num_m1;
    logic [swr_pkg::CNT_W:0]   disc;
    logic                      ae;
    logic                      fp;
    logic                      done;

    bc     = cur.buffered_count;
    es     = cur.expected_start;
    lio    = cur.last_in_order;
    ae     = cur.ack_enable;
    fp     = cur.flush_pending;
    done   = item.short_payload;
    num_m1 = {1'b0, item.packet_number} - swr_pkg::LIO_W'(1);
    disc   = '0;
    res    = '0;

    // Pending flush: commit if at expected start, else discard and resync
    if (fp) begin
      if (item.packet_number != es) begin
        ae   = 1'b1;
        es   = item.packet_number;
        disc = disc + {1'b0, bc};
      end else begin
        res.commit_count = bc;
      end
      bc  = '0;
      fp  = 1'b0;
      lio = num_m1;
    end

    // Window restart
    if (es == item.packet_number) begin
      ae   = 1'b1;
      lio  = {1'b0, es} - swr_pkg::LIO_W'(1);
      disc = disc + {1'b0, bc};
      bc   = '0;
    end

    // In-order check
    if (lio != num_m1) begin
      lio  = (item.packet_number >= win) ? win_m1 : swr_pkg::LIO_NONE;
      disc = disc + {1'b0, bc};
      bc   = '0;
      done = 1'b0;
      ae   = 1'b0;
      fp   = 1'b0;
    end else begin
      lio          = {1'b0, item.packet_number};
      res.accepted = 1'b1;
      res.slot     = bc;
      if (bc != swr_pkg::COUNT_MAX) begin
        bc = bc + swr_pkg::CNT_W'(1);
      end
    end

    // Cumulative ack at a window end
    if (!done && ae && (lio == win_m1 || lio == win2_m1)) begin
      res.ack_valid  = 1'b1;
      res.ack_number = lio[swr_pkg::NUM_W-1:0];
      if (lio == win2_m1) begin
        lio = swr_pkg::LIO_NONE;
      end
      es = (es == '0) ? win : '0;
      fp = 1'b1;
    end

    res.discard_count = disc[swr_pkg::CNT_W] ? swr_pkg::COUNT_MAX
                                             : disc[swr_pkg::CNT_W-1:0];

    // Completion returns to the reset state
    if (done) begin
      res.finished    = 1'b1;
      res.final_count = bc;
      nxt             = swr_pkg::STATE_RESET;
    end else begin
      nxt.buffered_count = bc;
      nxt.expected_start = es;
      nxt.last_in_order  = lio;
      nxt.ack_enable     = ae;
      nxt.flush_pending  = fp;
    end
  end

endmodule

// ===== rtl/core/sliding_window_receiver_unit.sv =====
`timescale 1ns / 1ps
// Pipeline from input transaction to result: input register, then result register.
// Throughput: 1 packet per cycle without result stall; single compare-and-update pass.
// A stalled result register holds the input side only once the input register is full.
// Reset (synchronous, rst_n low): window_size = 4, buffered count and window start 0,
// last in-order number -1, acks enabled, no flush pending, both stages empty.
// ---------------------------------------------------------------------------
// sliding_window_receiver_unit: go-back-N style receiver, two-window sequence
// Decides commit, discard, slot, ack and completion for each packet header.
// ---------------------------------------------------------------------------
module sliding_window_receiver_unit #(
  parameter int WINDOW_MAX = swr_pkg::WINDOW_MAX_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Configuration: window_size
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [swr_pkg::NUM_W-1:0]         cfg_data,
  // Input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [swr_pkg::IN_TDATA_W-1:0]    in_tdata,   // [7:0] packet_number
  input  logic                              in_tlast,   // short_payload
  // Result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [7:0] commit_count, [15:8] discard_count, [16] accepted, [24:17] slot,
  // [25] ack_valid, [33:26] ack_number, [41:34] final_count, [47:42] zero
  output logic [swr_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                              out_tlast   // finished
);

  logic                      cfg_write;
  logic [swr_pkg::NUM_W-1:0] window_size_r;
  logic                      item_valid;
  swr_pkg::item_t            item;
  logic                      advance;
  swr_pkg::state_t           state_r, state_nxt;
  swr_pkg::result_t          res, res_r;
  logic                      out_valid_r, out_valid_nxt;

  assign cfg_write = cfg_valid;
  assign cfg_ready = 1'b1;

  // Window size register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r <= swr_pkg::WINDOW_SIZE_RESET;
    end else if (cfg_write && cfg_ready) begin
      window_size_r <= cfg_data;
    end
  end

  swr_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .take       (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  // Process when the result register is free or draining
  assign advance = item_valid && (!out_valid_r || out_tready);

  swr_step #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_step (
    .window_size (window_size_r),
    .cur         (state_r),
    .item        (item),
    .nxt         (state_nxt),
    .res         (res)
  );

  // Receiver state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= swr_pkg::STATE_RESET;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // Result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  // Pack result fields
  assign out_tvalid = out_valid_r;
  assign out_tlast  = res_r.finished;
  assign out_tdata  = {
    (swr_pkg::OUT_TDATA_W - swr_pkg::OUT_FIELD_W)'(0),
    res_r.final_count,
    res_r.ack_number,
    res_r.ack_valid,
    res_r.slot,
    res_r.accepted,
    res_r.discard_count,
    res_r.commit_count
  };

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: testbench for sliding_window_receiver_unit
// Streams packet headers into the receiver and predicts the commit,
// discard, slot, ack and completion verdict of each one in a scoreboard.
// Every verdict on the result stream is checked field by field. The run
// sweeps window sizes (out-of-range values included), random gaps on both
// sides, a long result stall and a run that fills the block buffer.
// ---------------------------------------------------------------------------

// Scoreboard: carries its own copy of the receiver state and queues the
// verdict each packet is due to produce
class receiver_scoreboard;
  logic [7:0] window_reg;
  logic [7:0] buf_cnt;
  logic [7:0] win_start;
  int         last_num;      // -1 when nothing is in order yet
  bit         acks_on;
  bit         flush_due;

  swr_pkg::result_t verdicts_due[$];
  int errors;
  int n_packets, n_accepted, n_acks, n_finished, n_commits;

  function new();
    window_reg = swr_pkg::WINDOW_SIZE_RESET;
    clear_session();
  endfunction

  function void clear_session();
    buf_cnt   = '0;
    win_start = '0;
    last_num  = -1;
    acks_on   = 1'b1;
    flush_due = 1'b0;
  endfunction

  function void set_window(logic [7:0] value);
    window_reg = value;
  endfunction

  function bit at_reset_state();
    return buf_cnt == 0 && win_start == 0 && last_num == -1 && acks_on && !flush_due;
  endfunction

  // A number the receiver takes in order from here, or 0 at the top of the space
  function logic [7:0] next_in_order();
    return (last_num >= 0 && last_num < 255) ? 8'(last_num + 1) : 8'd0;
  endfunction

  function int waiting();
    return verdicts_due.size();
  endfunction

  // Predict the verdict for one accepted packet header
  function void predict_verdict(swr_pkg::item_t pkt);
    int w, num, discard;
    bit done;
    swr_pkg::result_t r;
    r       = '0;
    discard = 0;
    num     = int'(pkt.packet_number);
    done    = pkt.short_payload;
    w       = (window_reg == 0) ? 1 :
              (int'(window_reg) > swr_pkg::WINDOW_MAX_DEF) ? swr_pkg::WINDOW_MAX_DEF :
              int'(window_reg);

    // first packet after an ack: commit if it is the next window, else discard
    if (flush_due) begin
      if (num != int'(win_start)) begin
        acks_on   = 1'b1;
        win_start = 8'(num);
        discard  += int'(buf_cnt);
      end else begin
        r.commit_count = buf_cnt;
      end
      buf_cnt   = '0;
      flush_due = 1'b0;
      last_num  = num - 1;
    end

    // start of the expected window restarts buffering
    if (int'(win_start) == num) begin
      acks_on  = 1'b1;
      last_num = int'(win_start) - 1;
      discard += int'(buf_cnt);
      buf_cnt  = '0;
    end

    // in order: buffer it; otherwise drop and fall back to a window boundary
    if (num - last_num != 1) begin
      last_num  = (num > w - 1) ? w - 1 : -1;
      discard  += int'(buf_cnt);
      buf_cnt   = '0;
      done      = 1'b0;
      acks_on   = 1'b0;
      flush_due = 1'b0;
    end else begin
      last_num   = num;
      r.accepted = 1'b1;
      r.slot     = buf_cnt;
      if (buf_cnt != swr_pkg::COUNT_MAX) buf_cnt++;
    end

    // cumulative ack at either window end
    if (!done && acks_on && (last_num == w - 1 || last_num == 2 * w - 1)) begin
      r.ack_valid  = 1'b1;
      r.ack_number = last_num[7:0];
      if (last_num == 2 * w - 1) last_num = -1;
      win_start = (win_start == 0) ? w[7:0] : 8'd0;
      flush_due = 1'b1;
    end

    if (done) begin
      r.finished    = 1'b1;
      r.final_count = buf_cnt;
      clear_session();
    end

    r.discard_count = (discard > 255) ? 8'd255 : 8'(discard);
    verdicts_due.push_back(r);
    n_packets++;
    n_accepted += r.accepted;
    n_acks     += r.ack_valid;
    n_finished += r.finished;
    n_commits  += (r.commit_count != 0);
  endfunction

  task report(string msg);
    errors++;
    $display("ERROR at %0t: %s", $time, msg);
  endtask

  task compare_field(string name, int got, int want);
    if (got != want) report($sformatf("%s got %0d, wanted %0d", name, got, want));
  endtask

  // Check one result transaction against the oldest predicted verdict
  task check_result(logic [swr_pkg::OUT_TDATA_W-1:0] data, logic last);
    swr_pkg::result_t want;
    if (verdicts_due.size() == 0) begin
      report($sformatf("unexpected result 0x%012h", data));
    end else begin
      want = verdicts_due.pop_front();
      compare_field("commit_count", data[7:0], want.commit_count);
      compare_field("discard_count", data[15:8], want.discard_count);
      compare_field("accepted", data[16], want.accepted);
      compare_field("slot", data[24:17], want.slot);
      compare_field("ack_valid", data[25], want.ack_valid);
      compare_field("ack_number", data[33:26], want.ack_number);
      compare_field("final_count", data[41:34], want.final_count);
      compare_field("finished", last, want.finished);
      compare_field("padding", data[47:42], 0);
    end
  endtask
endclass

module tb;
  localparam int SEG_ITEMS   = 125;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [swr_pkg::NUM_W-1:0] cfg_data = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [swr_pkg::IN_TDATA_W-1:0] in_tdata = '0;   // [7:0] packet_number
  logic in_tlast = 1'b0;                          // short_payload
  logic out_tvalid;
  logic out_tready = 1'b0;
  // [7:0] commit_count, [15:8] discard_count, [16] accepted, [24:17] slot,
  // [25] ack_valid, [33:26] ack_number, [41:34] final_count, [47:42] zero
  logic [swr_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic out_tlast;                                // finished

  int send_gap_pct = 6;
  int recv_gap_pct = 70;
  bit hold_req = 1'b0;
  bit hold_active = 1'b0;

  receiver_scoreboard board;

  sliding_window_receiver_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #2 clk = ~clk;

  // Send one packet header; called and returns at a falling edge
  task automatic send_packet(input logic [7:0] num, input logic short_pkt);
    swr_pkg::item_t pkt;
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= num;
    in_tlast  <= short_pkt;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pkt.packet_number = num;
    pkt.short_payload = short_pkt;
    board.predict_verdict(pkt);
    @(negedge clk);
  endtask

  // Stop sending and let every predicted verdict come out
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (board.waiting() != 0) @(negedge clk);
    repeat (2) @(negedge clk);   // two-stage pipeline settles
  endtask

  task automatic write_window(input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.set_window(value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Result side: check at the rising edge, choose ready at the falling edge
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata, out_tlast);
      @(negedge clk);
      out_tready <= !hold_active && ($urandom_range(0, 99) >= recv_gap_pct);
    end
  end

  // Long result stall, timed on its own
  initial begin
    forever begin
      wait (hold_req);
      hold_active = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_active = 1'b0;
      hold_req    = 1'b0;
    end
  end

  // Watchdog
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL");
    $finish;
  end

  // Stimulus
  initial begin
    logic [8:0] opening [20];
    logic [7:0] seg_windows [9];
    logic [7:0] win, num;
    logic short_pkt;
    int span, next_num, roll;

    // {short_payload, packet_number}
    opening = '{
      {1'b0, 8'd0}, {1'b0, 8'd1}, {1'b0, 8'd2}, {1'b0, 8'd3},     // ack at first window end
      {1'b0, 8'd4}, {1'b0, 8'd5}, {1'b0, 8'd6}, {1'b0, 8'd7},     // commit, ack at wrap
      {1'b0, 8'd7},                                               // retransmit after ack
      {1'b1, 8'd9},                                               // short, in order: done
      {1'b0, 8'd4}, {1'b0, 8'd5}, {1'b1, 8'd6},                   // dropped: out of order
      {1'b1, 8'd255}, {1'b0, 8'd128}, {1'b0, 8'd0}, {1'b0, 8'd1},
      {1'b0, 8'd2}, {1'b0, 8'd3}, {1'b1, 8'd170}
    };
    seg_windows = '{8'd1, 8'd128, 8'd0, 8'd255, 8'd2, 8'd3, 8'd7, 8'd64, 8'd4};

    board = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed opening at the reset window size
    foreach (opening[i]) send_packet(opening[i][7:0], opening[i][8]);
    drain_results();

    // Random traffic, one window size per segment
    for (int seg = 0; seg < 9; seg++) begin
      if (seg < 3) begin
        send_gap_pct = 6;
        recv_gap_pct = 70;
      end else if (seg < 6) begin
        send_gap_pct = 70;
        recv_gap_pct = 6;
      end else begin
        send_gap_pct = 0;
        recv_gap_pct = 0;
      end
      win = (seg == 8) ? 8'($urandom_range(1, 255)) : seg_windows[seg];
      write_window(win);
      span = (win == 0) ? 1 : (int'(win) > swr_pkg::WINDOW_MAX_DEF) ?
             swr_pkg::WINDOW_MAX_DEF : int'(win);
      if (seg == 6) hold_req = 1'b1;   // block fills while the sender keeps going

      // Mostly a well-behaved sender with go-back, gaps and a stray packet now and then
      next_num = 0;
      for (int i = 0; i < SEG_ITEMS; i++) begin
        roll = $urandom_range(0, 99);
        if (roll < 90) begin
          if (roll < 8) next_num = (next_num / span) * span;
          else if (roll < 14) next_num = (next_num + 1) % (2 * span);
          num       = next_num[7:0];
          short_pkt = ($urandom_range(0, 99) < 3);
          next_num  = short_pkt ? 0 : (next_num + 1) % (2 * span);
        end else begin
          num       = 8'($urandom_range(0, 255));
          short_pkt = 1'($urandom_range(0, 1));
        end
        send_packet(num, short_pkt);
      end
      drain_results();
    end

    // Fill the buffer: park the window start at 255, turn acks off, then
    // run 0..254 in order and finish on the last one
    write_window(8'd4);
    while (!board.at_reset_state()) send_packet(board.next_in_order(), 1'b1);
    for (int n = 0; n < 4; n++) send_packet(8'(n), 1'b0);
    send_packet(8'd255, 1'b0);
    send_packet(8'd0, 1'b0);
    for (int n = 0; n < 255; n++) send_packet(8'(n), n == 254);
    drain_results();
    repeat (10) @(posedge clk);

    $display("Covered %0d packets over ten window settings incl. 0 and 255:",
             board.n_packets);
    $display("  %0d accepted, %0d acks, %0d commits, %0d completions, %0d errors",
             board.n_accepted, board.n_acks, board.n_commits, board.n_finished,
             board.errors);
    if (board.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

// ===== sliding_window_receiver_unit.f =====
rtl/core/swr_pkg.sv
rtl/core/swr_in_reg.sv
rtl/core/swr_step.sv
rtl/core/sliding_window_receiver_unit.sv
dv/tb.sv
